/* rtl/pps_pkg.sv */
// particle pool euler step: shared types, codes and constants
// no dependencies; imported by every module of the block
package pps_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 31;
  localparam int RATE_W = 17;
  localparam int LIVE_W = 7;
  localparam int ADDR_W = 4;
  localparam int OP_W   = 4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] REG_FRICTION = 2'd0;
  localparam logic [1:0] REG_DECAY    = 2'd1;
  localparam logic [1:0] REG_GRAVITY  = 2'd2;

  localparam logic [RATE_W-1:0] FRICTION_RST = 17'd5243;
  localparam logic [RATE_W-1:0] DECAY_RST    = 17'd655;
  localparam logic [RATE_W-1:0] GRAVITY_RST  = 17'd655;

  // multiplier operations
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_VSX  = 4'd1;
  localparam logic [OP_W-1:0] OP_VSY  = 4'd2;
  localparam logic [OP_W-1:0] OP_VSZ  = 4'd3;
  localparam logic [OP_W-1:0] OP_FR   = 4'd4;
  localparam logic [OP_W-1:0] OP_GR   = 4'd5;
  localparam logic [OP_W-1:0] OP_DR   = 4'd6;
  localparam logic [OP_W-1:0] OP_PX   = 4'd7;
  localparam logic [OP_W-1:0] OP_PY   = 4'd8;
  localparam logic [OP_W-1:0] OP_PZ   = 4'd9;
  localparam logic [OP_W-1:0] OP_VXD  = 4'd10;
  localparam logic [OP_W-1:0] OP_VYD  = 4'd11;
  localparam logic [OP_W-1:0] OP_VZD  = 4'd12;

  typedef struct packed {
    logic [RATE_W-1:0] friction;
    logic [RATE_W-1:0] decay;
    logic [RATE_W-1:0] gravity;
  } cfg_t;

  typedef struct packed {
    logic            ld_in;
    logic            ld_dt;
    logic            ld_mem;
    logic            wr_en;
    logic            wr_upd;
    logic            out_ld_mem;
    logic            out_ld_blank;
    logic            blank_acc;
    logic            out_last;
    logic [OP_W-1:0] mul_op;
  } cmd_t;

  typedef struct packed {
    logic size_pos;
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] vz;
    logic signed [DATA_W-1:0] sz;
  } particle_t;

endpackage

/* rtl/pps_regs.sv */
// configuration registers behind the apb-style port
// depends on pps_pkg
module pps_regs import pps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.friction <= FRICTION_RST;
      cfg.decay    <= DECAY_RST;
      cfg.gravity  <= GRAVITY_RST;
    end else if (wr) begin
      case (idx)
        REG_FRICTION: cfg.friction <= pwdata[RATE_W-1:0];
        REG_DECAY:    cfg.decay    <= pwdata[RATE_W-1:0];
        REG_GRAVITY:  cfg.gravity  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRICTION: prdata = 32'(cfg.friction);
      REG_DECAY:    prdata = 32'(cfg.decay);
      REG_GRAVITY:  prdata = 32'(cfg.gravity);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/pps_ctrl.sv */
// sequencer: walks slots, issues multiplier ops, drives handshakes
// depends on pps_pkg; commands pps_dp
module pps_ctrl import pps_pkg::*; #(
  parameter int PARTICLE_SLOTS = 64,
  localparam int CW = $clog2(PARTICLE_SLOTS + 1),
  localparam int AW = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          cmd,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  status_t       status,
  output cmd_t          ctl,
  output logic [AW-1:0] addr,
  output logic [CW-1:0] live
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_ADD_WR = 4'd2;
  localparam logic [3:0] S_PRE    = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_LD     = 4'd5;
  localparam logic [3:0] S_UPD    = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_ERD    = 4'd8;
  localparam logic [3:0] S_ELD    = 4'd9;
  localparam logic [3:0] S_BLANK  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]    state;
  logic [2:0]    step;
  logic [CW-1:0] i;
  logic          swap;
  logic          acc;
  logic          last_q;
  logic          take;
  logic          is_last;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign take      = in_valid && (state == S_IDLE);
  assign is_last   = ((i + 1'b1) == live);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      i      <= '0;
      live   <= '0;
      swap   <= 1'b0;
      acc    <= 1'b0;
      last_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (in_valid) begin
            if (cmd == CMD_TICK) begin
              state <= S_PRE;
            end else if (live < CW'(PARTICLE_SLOTS)) begin
              acc   <= 1'b1;
              state <= S_ADD;
            end else begin
              acc   <= 1'b0;
              state <= S_BLANK;
            end
          end
        end
        S_ADD: begin
          step <= step + 1'b1;
          if (step == 3'd3) state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          live  <= live + 1'b1;
          state <= S_BLANK;
        end
        S_PRE: begin
          step <= step + 1'b1;
          if (step == 3'd3) begin
            i     <= '0;
            swap  <= 1'b0;
            acc   <= 1'b0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          step <= '0;
          if (i < live) begin
            state <= S_LD;
          end else if (live == '0) begin
            state <= S_BLANK;
          end else begin
            i     <= '0;
            state <= S_ERD;
          end
        end
        S_LD: state <= S_UPD;
        S_UPD: begin
          step <= step + 1'b1;
          if (step == 3'd6) state <= S_CHK;
        end
        S_CHK: begin
          if (status.size_pos) begin
            i    <= i + 1'b1;
            swap <= 1'b0;
          end else begin
            live <= live - 1'b1;
            swap <= 1'b1;
          end
          state <= S_NEXT;
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          last_q <= is_last;
          state  <= S_OUT;
        end
        S_BLANK: begin
          last_q <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (last_q) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl  = '0;
    addr = i[AW-1:0];
    ctl.mul_op = OP_NONE;
    case (state)
      S_IDLE: begin
        ctl.ld_in = take && (cmd == CMD_ADD);
        ctl.ld_dt = take && (cmd == CMD_TICK);
      end
      S_ADD: begin
        case (step)
          3'd0:    ctl.mul_op = OP_VSX;
          3'd1:    ctl.mul_op = OP_VSY;
          3'd2:    ctl.mul_op = OP_VSZ;
          default: ctl.mul_op = OP_NONE;
        endcase
      end
      S_ADD_WR: begin
        ctl.wr_en = 1'b1;
        addr      = live[AW-1:0];
      end
      S_PRE: begin
        case (step)
          3'd0:    ctl.mul_op = OP_FR;
          3'd1:    ctl.mul_op = OP_GR;
          3'd2:    ctl.mul_op = OP_DR;
          default: ctl.mul_op = OP_NONE;
        endcase
      end
      S_NEXT: addr = swap ? live[AW-1:0] : i[AW-1:0];
      S_LD:   ctl.ld_mem = 1'b1;
      S_UPD: begin
        case (step)
          3'd0:    ctl.mul_op = OP_PX;
          3'd1:    ctl.mul_op = OP_PY;
          3'd2:    ctl.mul_op = OP_PZ;
          3'd3:    ctl.mul_op = OP_VXD;
          3'd4:    ctl.mul_op = OP_VYD;
          3'd5:    ctl.mul_op = OP_VZD;
          default: ctl.mul_op = OP_NONE;
        endcase
      end
      S_CHK: begin
        ctl.wr_en  = status.size_pos;
        ctl.wr_upd = 1'b1;
      end
      S_ELD: begin
        ctl.out_ld_mem = 1'b1;
        ctl.out_last   = is_last;
      end
      S_BLANK: begin
        ctl.out_ld_blank = 1'b1;
        ctl.blank_acc    = acc;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pps_dp.sv */
// datapath: particle memory, working registers, shared 32x32 multiplier,
// saturating adders and result register; depends on pps_pkg
module pps_dp import pps_pkg::*; #(
  parameter int PARTICLE_SLOTS = 64,
  parameter int FRAC_BITS = 16,
  localparam int CW = $clog2(PARTICLE_SLOTS + 1),
  localparam int AW = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1
) (
  input  logic                     clk,
  input  cmd_t                     ctl,
  input  logic [AW-1:0]            addr,
  input  logic [CW-1:0]            live,
  input  cfg_t                     cfg,
  output status_t                  status,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic [SIZE_W-1:0]        particle_size,
  input  logic [SIZE_W-1:0]        time_step,
  output logic                     has_particle,
  output logic signed [DATA_W-1:0] out_pos_x,
  output logic signed [DATA_W-1:0] out_pos_y,
  output logic signed [DATA_W-1:0] out_pos_z,
  output logic signed [DATA_W-1:0] out_vel_x,
  output logic signed [DATA_W-1:0] out_vel_y,
  output logic signed [DATA_W-1:0] out_vel_z,
  output logic [SIZE_W-1:0]        out_size,
  output logic [LIVE_W-1:0]        live_total,
  output logic                     accepted,
  output logic                     last
);

  localparam logic signed [DATA_W:0] ONE = 33'sd1 <<< FRAC_BITS;

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 33'sh0_7FFF_FFFF)      r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else                           r = v[DATA_W-1:0];
    return r;
  endfunction

  particle_t mem [PARTICLE_SLOTS];
  particle_t rdata;
  particle_t wword;

  logic signed [DATA_W-1:0]   wpx, wpy, wpz, wvx, wvy, wvz, wsz;
  logic signed [DATA_W-1:0]   damp, grav, shrink, dt;
  logic signed [DATA_W-1:0]   ma, mb, r, nsz;
  logic signed [2*DATA_W-1:0] prod, q;
  logic [OP_W-1:0]            op_q;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.mul_op)
      OP_VSX: begin ma = wvx; mb = wsz; end
      OP_VSY: begin ma = wvy; mb = wsz; end
      OP_VSZ: begin ma = wvz; mb = wsz; end
      OP_FR:  begin ma = signed'(DATA_W'(cfg.friction)); mb = dt; end
      OP_GR:  begin ma = signed'(DATA_W'(cfg.gravity));  mb = dt; end
      OP_DR:  begin ma = signed'(DATA_W'(cfg.decay));    mb = dt; end
      OP_PX:  begin ma = wvx; mb = dt; end
      OP_PY:  begin ma = wvy; mb = dt; end
      OP_PZ:  begin ma = wvz; mb = dt; end
      OP_VXD: begin ma = wvx; mb = damp; end
      OP_VYD: begin ma = wvy; mb = damp; end
      OP_VZD: begin ma = wvz; mb = damp; end
      default: ;
    endcase
  end

  // floor shift then clamp
  always_comb begin
    q = prod >>> FRAC_BITS;
    if (q > 64'sh0000_0000_7FFF_FFFF)      r = 32'sh7FFF_FFFF;
    else if (q < 64'shFFFF_FFFF_8000_0000) r = 32'sh8000_0000;
    else                                   r = q[DATA_W-1:0];
  end

  assign nsz             = sat33(33'(wsz) - 33'(shrink));
  assign status.size_pos = (nsz > 32'sd0);

  always_comb begin
    wword.px = wpx;
    wword.py = wpy;
    wword.pz = wpz;
    wword.vx = wvx;
    wword.vy = wvy;
    wword.vz = wvz;
    wword.sz = ctl.wr_upd ? nsz : wsz;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[addr] <= wword;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    op_q <= ctl.mul_op;
    if (ctl.ld_dt) dt <= signed'({1'b0, time_step});
    if (ctl.ld_in) begin
      wpx <= pos_x;
      wpy <= pos_y;
      wpz <= pos_z;
      wvx <= vel_x;
      wvy <= vel_y;
      wvz <= vel_z;
      wsz <= signed'({1'b0, particle_size});
    end else if (ctl.ld_mem) begin
      wpx <= rdata.px;
      wpy <= rdata.py;
      wpz <= rdata.pz;
      wvx <= rdata.vx;
      wvy <= rdata.vy;
      wvz <= rdata.vz;
      wsz <= rdata.sz;
    end else begin
      case (op_q)
        OP_VSX: wvx <= r;
        OP_VSY: wvy <= r;
        OP_VSZ: wvz <= r;
        OP_FR:  damp <= sat33(ONE - 33'(r));
        OP_GR:  grav <= r;
        OP_DR:  shrink <= r;
        OP_PX:  wpx <= sat33(33'(wpx) + 33'(r));
        OP_PY:  wpy <= sat33(33'(wpy) + 33'(r));
        OP_PZ:  wpz <= sat33(33'(wpz) + 33'(r));
        OP_VXD: wvx <= r;
        OP_VYD: wvy <= sat33(33'(r) - 33'(grav));
        OP_VZD: wvz <= r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld_mem) begin
      has_particle <= 1'b1;
      out_pos_x    <= rdata.px;
      out_pos_y    <= rdata.py;
      out_pos_z    <= rdata.pz;
      out_vel_x    <= rdata.vx;
      out_vel_y    <= rdata.vy;
      out_vel_z    <= rdata.vz;
      out_size     <= rdata.sz[SIZE_W-1:0];
      live_total   <= LIVE_W'(live);
      accepted     <= 1'b0;
      last         <= ctl.out_last;
    end else if (ctl.out_ld_blank) begin
      has_particle <= 1'b0;
      out_pos_x    <= '0;
      out_pos_y    <= '0;
      out_pos_z    <= '0;
      out_vel_x    <= '0;
      out_vel_y    <= '0;
      out_vel_z    <= '0;
      out_size     <= '0;
      live_total   <= LIVE_W'(live);
      accepted     <= ctl.blank_acc;
      last         <= 1'b1;
    end
  end

endmodule

/* rtl/particle_pool_euler_step.sv */
// particle pool euler step, top level: registers, sequencer and datapath
// depends on pps_pkg, pps_regs, pps_ctrl, pps_dp
//
//   channel | handshake          | word
//   in      | in_valid/in_stall  | cmd, pos_*, vel_*, particle_size, time_step
//   out     | out_valid/out_stall| has_particle, out_*, live_total, accepted, last
//   cfg     | psel/penable/pready| paddr, pwdata, prdata
//
// add: one item at a time; in_stall stays high until its result word has gone
// tick: setup products, then one slot visit per particle on the single shared
//   multiplier, then one result word per live particle, or a blank one if none
// reset clears the live count and sequencer; particle memory is not cleared
// out_stall holds the result register and the sequencer in place
module particle_pool_euler_step import pps_pkg::*; #(
  parameter int PARTICLE_SLOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic [SIZE_W-1:0]        particle_size,
  input  logic [SIZE_W-1:0]        time_step,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     has_particle,
  output logic signed [DATA_W-1:0] out_pos_x,
  output logic signed [DATA_W-1:0] out_pos_y,
  output logic signed [DATA_W-1:0] out_pos_z,
  output logic signed [DATA_W-1:0] out_vel_x,
  output logic signed [DATA_W-1:0] out_vel_y,
  output logic signed [DATA_W-1:0] out_vel_z,
  output logic [SIZE_W-1:0]        out_size,
  output logic [LIVE_W-1:0]        live_total,
  output logic                     accepted,
  output logic                     last
);

  localparam int CW = $clog2(PARTICLE_SLOTS + 1);
  localparam int AW = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;

  cfg_t          cfg;
  cmd_t          ctl;
  status_t       status;
  logic [AW-1:0] addr;
  logic [CW-1:0] live;

  pps_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pps_ctrl #(.PARTICLE_SLOTS(PARTICLE_SLOTS)) u_ctrl (
    .clk, .rst, .in_valid, .cmd, .in_stall, .out_valid, .out_stall,
    .status, .ctl, .addr, .live
  );

  pps_dp #(.PARTICLE_SLOTS(PARTICLE_SLOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .ctl, .addr, .live, .cfg, .status,
    .pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z, .particle_size, .time_step,
    .has_particle, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_vel_x, .out_vel_y, .out_vel_z, .out_size,
    .live_total, .accepted, .last
  );

endmodule

/* rtl/pps_checker.sv */
// port-level checks for particle_pool_euler_step, with its bind
// depends on pps_pkg
module pps_checker import pps_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              has_particle,
  input logic              accepted,
  input logic              last,
  input logic [LIVE_W-1:0] live_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result word is pending");

  a_particle: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_particle |-> !accepted && live_total != '0)
    else $error("particle word with bad status");

  a_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_particle |-> last)
    else $error("blank word not marked last");

endmodule

bind particle_pool_euler_step pps_checker u_pps_checker (.*);

/* tb/tb.sv */
// testbench for particle_pool_euler_step: random and directed add/tick words
// with a self-contained fixed point pool predictor and in-order result checking
// depends on pps_pkg and the rtl of particle_pool_euler_step
module tb;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                     has_p;
    logic signed [31:0]       px, py, pz, vx, vy, vz;
    logic [SIZE_W-1:0]        sz;
    logic [LIVE_W-1:0]        live;
    logic                     acc;
    logic                     lst;
  } result_t;

  class pool_board;
    logic signed [31:0] ppx[64], ppy[64], ppz[64], pvx[64], pvy[64], pvz[64], psz[64];
    int unsigned count;
    logic [16:0] fric, dec, grav;
    result_t pending[$];
    int errors;

    function new();
      count = 0; fric = FRICTION_RST; dec = DECAY_RST; grav = GRAVITY_RST; errors = 0;
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(longint a, longint b);
      longint p;
      p = a * b;
      return sat(p >>> 16);
    endfunction

    function result_t blank(logic acc);
      result_t r;
      r = '{default: 0};
      r.live = LIVE_W'(count); r.acc = acc; r.lst = 1;
      return r;
    endfunction

    function void note_word(logic c, logic signed [31:0] x, y, z, a, b, d,
                            logic [30:0] s, logic [30:0] dt);
      longint damp, gv, shr;
      int unsigned i, k;
      result_t r;
      if (c == CMD_ADD) begin
        if (count < 64) begin
          ppx[count] = x; ppy[count] = y; ppz[count] = z;
          pvx[count] = qmul(a, s); pvy[count] = qmul(b, s); pvz[count] = qmul(d, s);
          psz[count] = {1'b0, s};
          count++;
          pending.push_back(blank(1));
        end else pending.push_back(blank(0));
        return;
      end
      damp = sat(65536 - longint'(qmul(fric, dt)));
      gv = qmul(grav, dt);
      shr = qmul(dec, dt);
      i = 0;
      while (i < count) begin
        ppx[i] = sat(longint'(ppx[i]) + qmul(pvx[i], dt));
        ppy[i] = sat(longint'(ppy[i]) + qmul(pvy[i], dt));
        ppz[i] = sat(longint'(ppz[i]) + qmul(pvz[i], dt));
        pvx[i] = qmul(pvx[i], damp);
        pvy[i] = sat(longint'(qmul(pvy[i], damp)) - gv);
        pvz[i] = qmul(pvz[i], damp);
        psz[i] = sat(longint'(psz[i]) - shr);
        if (psz[i] <= 0) begin
          k = count - 1;
          ppx[i] = ppx[k]; ppy[i] = ppy[k]; ppz[i] = ppz[k];
          pvx[i] = pvx[k]; pvy[i] = pvy[k]; pvz[i] = pvz[k]; psz[i] = psz[k];
          count--;
        end else i++;
      end
      if (count == 0) begin
        pending.push_back(blank(0));
        return;
      end
      for (i = 0; i < count; i++) begin
        r.has_p = 1; r.px = ppx[i]; r.py = ppy[i]; r.pz = ppz[i];
        r.vx = pvx[i]; r.vy = pvy[i]; r.vz = pvz[i]; r.sz = psz[i][30:0];
        r.live = LIVE_W'(count); r.acc = 0; r.lst = (i + 1 == count);
        pending.push_back(r);
      end
    endfunction

    function void check_word(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.has_p !== e.has_p) begin $error("has_particle exp %0d got %0d", e.has_p, got.has_p); errors++; end
      if (got.px !== e.px) begin $error("out_pos_x exp %0d got %0d", e.px, got.px); errors++; end
      if (got.py !== e.py) begin $error("out_pos_y exp %0d got %0d", e.py, got.py); errors++; end
      if (got.pz !== e.pz) begin $error("out_pos_z exp %0d got %0d", e.pz, got.pz); errors++; end
      if (got.vx !== e.vx) begin $error("out_vel_x exp %0d got %0d", e.vx, got.vx); errors++; end
      if (got.vy !== e.vy) begin $error("out_vel_y exp %0d got %0d", e.vy, got.vy); errors++; end
      if (got.vz !== e.vz) begin $error("out_vel_z exp %0d got %0d", e.vz, got.vz); errors++; end
      if (got.sz !== e.sz) begin $error("out_size exp %0d got %0d", e.sz, got.sz); errors++; end
      if (got.live !== e.live) begin $error("live_total exp %0d got %0d", e.live, got.live); errors++; end
      if (got.acc !== e.acc) begin $error("accepted exp %0d got %0d", e.acc, got.acc); errors++; end
      if (got.lst !== e.lst) begin $error("last exp %0d got %0d", e.lst, got.lst); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, cmd = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
  logic [SIZE_W-1:0] particle_size = 0, time_step = 0;
  logic out_valid, out_stall = 0, has_particle, accepted, last;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
  logic [SIZE_W-1:0] out_size;
  logic [LIVE_W-1:0] live_total;

  pool_board board = new();
  int unsigned cycles = 0, words_in = 0, words_out = 0, ticks_in = 0;
  bit hold_long = 0;

  always #2 clk = ~clk;

  particle_pool_euler_step u_dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t r;
    if (!rst && out_valid && !out_stall) begin
      r.has_p = has_particle; r.px = out_pos_x; r.py = out_pos_y; r.pz = out_pos_z;
      r.vx = out_vel_x; r.vy = out_vel_y; r.vz = out_vel_z; r.sz = out_size;
      r.live = live_total; r.acc = accepted; r.lst = last;
      board.check_word(r);
      words_out++;
    end
  end

  // receiver stall pattern
  initial begin
    int w;
    bit long_done;
    long_done = 0;
    forever begin
      @(negedge clk);
      if (hold_long && !long_done) begin
        out_stall <= 1;
        repeat (600) @(negedge clk);
        long_done = 1;
        out_stall <= 0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        out_stall <= (w != 0);
        if (w != 0) repeat (w - 1) @(negedge clk);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_FRICTION: board.fric = val;
      REG_DECAY:    board.dec = val;
      default:      board.grav = val;
    endcase
  endtask

  task automatic send_word(logic c, logic signed [31:0] x, y, z, a, b, d,
                           logic [30:0] s, logic [30:0] dt, bit gaps = 1);
    int g;
    g = gaps ? $urandom_range(0, 4) : 0;
    if (g != 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1; cmd <= c; pos_x <= x; pos_y <= y; pos_z <= z;
    vel_x <= a; vel_y <= b; vel_z <= d; particle_size <= s; time_step <= dt;
    do @(posedge clk); while (in_stall);
    board.note_word(c, x, y, z, a, b, d, s, dt);
    words_in++;
    if (c == CMD_TICK) ticks_in++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
    endcase
  endfunction

  task automatic rand_word(int tick_pct);
    logic [30:0] s, dt;
    s = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 32'h40000));
    dt = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h30000));
    send_word($urandom_range(0, 99) < tick_pct, rnd_val(), rnd_val(), rnd_val(),
              rnd_val(), rnd_val(), rnd_val(), s, dt);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty tick, extremes, removal with swap, saturation
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 31'h10000);
    send_word(CMD_ADD, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000,
              -1, 31'h7fffffff, 0);
    send_word(CMD_ADD, -1, 1, 32'sh7fffffff, 32'sh10000, -32'sh10000, 0, 31'h1, 31'h7fffffff);
    send_word(CMD_ADD, 0, 0, 0, 32'sh8000, 32'sh8000, 32'sh8000, 31'h20000, 0);
    send_word(CMD_ADD, 5, 6, 7, 0, 0, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 31'h7fffffff);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 31'h10000);
    drain();

    reg_write(REG_FRICTION, 17'h1ffff);
    reg_write(REG_DECAY, 17'h0);
    reg_write(REG_GRAVITY, 17'h10000);
    // fill the pool past full while the receiver holds off
    hold_long = 1;
    for (int i = 0; i < 66; i++) rand_word(0);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 31'h800);
    drain();

    reg_write(REG_FRICTION, 17'h0);
    reg_write(REG_DECAY, 17'h10000);
    reg_write(REG_GRAVITY, 17'h0);
    for (int i = 0; i < 40; i++) rand_word(35);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 31'h7fffffff);
    drain();

    reg_write(REG_FRICTION, 17'd5243);
    reg_write(REG_DECAY, 17'd655);
    reg_write(REG_GRAVITY, 17'd655);
    for (int i = 0; i < 70; i++) rand_word(25);
    drain();

    $display("covered %0d words (%0d ticks), %0d result words, full pool and register extremes",
             words_in, ticks_in, words_out);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/pps_pkg.sv
rtl/pps_regs.sv
rtl/pps_ctrl.sv
rtl/pps_dp.sv
rtl/particle_pool_euler_step.sv
rtl/pps_checker.sv
tb/tb.sv
